FILE: hdl/lfsab_pkg.sv
package lfsab_pkg;

  // Field widths of the request and result beats.
  localparam int FUNC_W   = 2;
  localparam int ID_W     = 10;
  localparam int WEIGHT_W = 14;
  localparam int SLOT_W   = 4;
  localparam int RATE_W   = 8;
  localparam int EV_W     = 3;
  localparam int CHARGE_W = 22;
  localparam int TOTAL_W  = 32;
  localparam int CFG_W    = 5;
  localparam int APB_AW   = 3;
  localparam int APB_DW   = 32;

  // Request function codes.
  localparam logic [FUNC_W-1:0] FUNC_ARRIVE = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_DEPART = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_LOAD   = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  // Result event codes.
  localparam logic [EV_W-1:0] EV_ASSIGNED = 3'd0;
  localparam logic [EV_W-1:0] EV_QUEUED   = 3'd1;
  localparam logic [EV_W-1:0] EV_RELEASED = 3'd2;
  localparam logic [EV_W-1:0] EV_LOADED   = 3'd3;
  localparam logic [EV_W-1:0] EV_NOTFOUND = 3'd4;
  localparam logic [EV_W-1:0] EV_FULL     = 3'd5;

  // Register word index of the slot count register.
  localparam logic REG_SLOTS = 1'b0;

  // Scan modes of the cell row.
  localparam logic SCAN_FREE  = 1'b0;
  localparam logic SCAN_OWNER = 1'b1;

  // One waiting requester.
  typedef struct packed {
    logic [ID_W-1:0]     id;
    logic [WEIGHT_W-1:0] weight;
  } q_entry_t;

  // Wait queue status.
  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

  // Command broadcast from the controller to every cell.
  typedef struct packed {
    logic                scan_run;
    logic                mode;
    logic [ID_W-1:0]     id;
    logic [WEIGHT_W-1:0] weight;
    logic                waiter_vld;
    q_entry_t            waiter;
    logic                load_en;
    logic [SLOT_W-1:0]   load_slot;
    logic [RATE_W-1:0]   load_rate;
  } cell_cmd_t;

  // What a cell reports back; data fields are zero unless it hits.
  typedef struct packed {
    logic                hit;
    logic [WEIGHT_W-1:0] weight;
    logic [RATE_W-1:0]   rate;
  } cell_stat_t;

endpackage

FILE: hdl/lfsab_cell.sv
module lfsab_cell #(
  parameter int IDX_W = 5,
  parameter int K     = 0
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  lfsab_pkg::cell_cmd_t  cmd,
  input  logic [IDX_W-1:0]      limit,
  input  logic                  tok_in,
  output logic                  tok_out,
  output lfsab_pkg::cell_stat_t stat
);
  import lfsab_pkg::*;

  logic                busy_r;
  logic                tok_r;
  logic [ID_W-1:0]     owner_r;
  logic [WEIGHT_W-1:0] weight_r;
  logic [RATE_W-1:0]   rate_r;
  logic                in_range;
  logic                hit;

  assign in_range = IDX_W'(K) < limit;

  // The cell holding the scan token decides whether the scan stops here.
  always_comb begin
    hit = 1'b0;
    if (cmd.scan_run && tok_r) begin
      if (cmd.mode == SCAN_FREE) begin
        hit = !busy_r && in_range;
      end else begin
        hit = busy_r && (owner_r == cmd.id);
      end
    end
  end

  // A token that does not hit moves on to the next cell.
  assign tok_out     = cmd.scan_run && tok_r && !hit;
  assign stat.hit    = hit;
  assign stat.weight = hit ? weight_r : '0;
  assign stat.rate   = hit ? rate_r : '0;

  // Busy flag and token position.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      tok_r  <= 1'b0;
    end else begin
      tok_r <= tok_in;
      if (hit) begin
        if (cmd.mode == SCAN_FREE) begin
          busy_r <= 1'b1;
        end else if (!cmd.waiter_vld) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  // Owner, weight and rate words.
  always_ff @(posedge clk) begin
    if (hit) begin
      if (cmd.mode == SCAN_FREE) begin
        owner_r  <= cmd.id;
        weight_r <= cmd.weight;
      end else if (cmd.waiter_vld) begin
        owner_r  <= cmd.waiter.id;
        weight_r <= cmd.waiter.weight;
      end
    end
    if (cmd.load_en && (int'(cmd.load_slot) == K)) begin
      rate_r <= cmd.load_rate;
    end
  end

endmodule

FILE: hdl/lfsab_queue.sv
module lfsab_queue #(
  parameter int DEPTH = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  lfsab_pkg::q_entry_t  push_data,
  input  logic                 pop,
  output lfsab_pkg::q_entry_t  head,
  output lfsab_pkg::q_stat_t   stat
);
  import lfsab_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  q_entry_t           mem [DEPTH];
  q_entry_t           rd_r;
  logic [PTR_W-1:0]   head_r;
  logic [PTR_W-1:0]   head_nxt;
  logic [PTR_W-1:0]   tail_r;
  logic [PTR_W-1:0]   tail_nxt;
  logic [CNT_W-1:0]   count_r;
  logic [CNT_W-1:0]   count_nxt;

  // Pointer and fill count updates, wrapping at the depth.
  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    if (push) begin
      tail_nxt  = (tail_r == PTR_LAST) ? '0 : tail_r + 1'b1;
      count_nxt = count_nxt + 1'b1;
    end
    if (pop) begin
      head_nxt  = (head_r == PTR_LAST) ? '0 : head_r + 1'b1;
      count_nxt = count_nxt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  // Entry storage; the head entry is read out every cycle.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[tail_r] <= push_data;
    end
    rd_r <= mem[head_r];
  end

  assign head       = rd_r;
  assign stat.empty = (count_r == '0);
  assign stat.full  = (count_r == CNT_W'(DEPTH));

endmodule

FILE: hdl/lowest_free_slot_allocator_billing_unit.sv
// Slot allocator with a wait queue and a saturating charge total. Slots live in a row of
// cells; a request walks a scan token along that row, one cell per cycle, so an arrival that
// lands in slot s or a departure of the owner of slot s scans slots 0 to s, and a scan
// that finds nothing covers min(slot count, NUM_SLOTS) slots for an arrival or all
// NUM_SLOTS slots for a departure. Beyond the scan, an item has an accept step, a release
// adds a multiply step for rate times weight and a saturating add step, and each result
// beat is held until taken. A rate load gives just its result beat. One request is
// in work at a time; the next is taken once the last result beat of the current one has been
// taken. There is no clearing pass after reset.
module lowest_free_slot_allocator_billing_unit #(
  parameter int NUM_SLOTS   = 16,
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [lfsab_pkg::FUNC_W-1:0]      in_func,
  input  logic [lfsab_pkg::ID_W-1:0]        in_requester_id,
  input  logic [lfsab_pkg::WEIGHT_W-1:0]    in_weight,
  input  logic [lfsab_pkg::SLOT_W-1:0]      in_load_slot,
  input  logic [lfsab_pkg::RATE_W-1:0]      in_load_rate,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [lfsab_pkg::EV_W-1:0]        out_event_res,
  output logic [lfsab_pkg::SLOT_W-1:0]      out_slot,
  output logic [lfsab_pkg::ID_W-1:0]        out_who,
  output logic [lfsab_pkg::CHARGE_W-1:0]    out_charge,
  output logic [lfsab_pkg::TOTAL_W-1:0]     out_total,
  output logic                              out_last,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [lfsab_pkg::APB_AW-1:0]      paddr,
  input  logic [lfsab_pkg::APB_DW-1:0]      pwdata,
  output logic [lfsab_pkg::APB_DW-1:0]      prdata,
  output logic                              pready
);
  import lfsab_pkg::*;

  localparam int IDX_W = $clog2(NUM_SLOTS + 1);

  typedef enum logic [5:0] {
    ST_IDLE     = 6'b000001,
    ST_SCAN     = 6'b000010,
    ST_MUL      = 6'b000100,
    ST_ADD      = 6'b001000,
    ST_OUT_A    = 6'b010000,
    ST_OUT_LAST = 6'b100000
  } state_t;

  state_t               state_r;
  state_t               state_nxt;
  logic [CFG_W-1:0]     cfg_slots_r;
  logic [IDX_W-1:0]     idx_r;
  logic [IDX_W-1:0]     idx_nxt;
  logic                 mode_r;
  logic                 mode_nxt;
  logic [ID_W-1:0]      id_r;
  logic [ID_W-1:0]      id_nxt;
  logic [WEIGHT_W-1:0]  w_r;
  logic [WEIGHT_W-1:0]  w_nxt;
  logic [RATE_W-1:0]    mul_rate_r;
  logic [RATE_W-1:0]    mul_rate_nxt;
  logic [WEIGHT_W-1:0]  mul_wt_r;
  logic [WEIGHT_W-1:0]  mul_wt_nxt;
  logic [CHARGE_W-1:0]  charge_r;
  logic [CHARGE_W-1:0]  charge_nxt;
  logic [TOTAL_W-1:0]   total_r;
  logic [TOTAL_W-1:0]   total_nxt;
  logic                 waiter_vld_r;
  logic                 waiter_vld_nxt;
  logic [ID_W-1:0]      waiter_id_r;
  logic [ID_W-1:0]      waiter_id_nxt;
  logic [EV_W-1:0]      out_event_r;
  logic [EV_W-1:0]      out_event_nxt;
  logic [SLOT_W-1:0]    out_slot_r;
  logic [SLOT_W-1:0]    out_slot_nxt;
  logic [ID_W-1:0]      out_who_r;
  logic [ID_W-1:0]      out_who_nxt;
  logic [CHARGE_W-1:0]  out_charge_r;
  logic [CHARGE_W-1:0]  out_charge_nxt;
  logic [TOTAL_W-1:0]   out_total_r;
  logic [TOTAL_W-1:0]   out_total_nxt;
  logic                 out_last_r;
  logic                 out_last_nxt;

  logic                 in_beat;
  logic                 out_beat;
  logic                 cfg_wr;
  logic                 start;
  logic                 load_en;
  logic                 q_push;
  logic                 q_pop;
  q_entry_t             q_head;
  q_stat_t              q_stat;
  q_entry_t             q_wdata;
  logic [IDX_W-1:0]     limit;
  logic [IDX_W-1:0]     scan_end;
  logic [TOTAL_W:0]     sum;
  cell_cmd_t            cmd;
  cell_stat_t           stat [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] tok_out;
  logic [NUM_SLOTS-1:0] hit_vec;
  logic                 any_hit;
  logic [WEIGHT_W-1:0]  hit_weight;
  logic [RATE_W-1:0]    hit_rate;

  assign in_beat  = in_valid && in_ready;
  assign out_beat = out_valid && out_ready;
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = (state_r == ST_OUT_A) || (state_r == ST_OUT_LAST);

  // Configuration port: one register, no wait states.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_SLOTS);
  assign prdata = (paddr[2] == REG_SLOTS) ? APB_DW'(cfg_slots_r) : '0;

  // Effective slot count, clamped to the row length.
  always_comb begin
    if (int'(cfg_slots_r) > NUM_SLOTS) begin
      limit = IDX_W'(NUM_SLOTS);
    end else begin
      limit = IDX_W'(cfg_slots_r);
    end
  end
  assign scan_end = (mode_r == SCAN_FREE) ? limit : IDX_W'(NUM_SLOTS);

  assign start   = in_beat && ((in_func == FUNC_ARRIVE) || (in_func == FUNC_DEPART));
  assign load_en = in_beat && (in_func == FUNC_LOAD);

  // Broadcast command to the cell row.
  always_comb begin
    cmd.scan_run   = (state_r == ST_SCAN);
    cmd.mode       = mode_r;
    cmd.id         = id_r;
    cmd.weight     = w_r;
    cmd.waiter_vld = !q_stat.empty;
    cmd.waiter     = q_head;
    cmd.load_en    = load_en;
    cmd.load_slot  = in_load_slot;
    cmd.load_rate  = in_load_rate;
  end

  // Row of slot cells with the scan token chained from cell to cell.
  for (genvar k = 0; k < NUM_SLOTS; k++) begin : g_cell
    lfsab_cell #(
      .IDX_W (IDX_W),
      .K     (k)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .cmd     (cmd),
      .limit   (limit),
      .tok_in  ((k == 0) ? start : tok_out[(k == 0) ? 0 : k - 1]),
      .tok_out (tok_out[k]),
      .stat    (stat[k])
    );
  end

  // Only the token holder can report, so the cell reports merge by OR.
  always_comb begin
    any_hit    = 1'b0;
    hit_weight = '0;
    hit_rate   = '0;
    for (int k = 0; k < NUM_SLOTS; k++) begin
      hit_vec[k] = stat[k].hit;
      any_hit    = any_hit | stat[k].hit;
      hit_weight = hit_weight | stat[k].weight;
      hit_rate   = hit_rate | stat[k].rate;
    end
  end

  assign q_wdata.id     = id_r;
  assign q_wdata.weight = w_r;

  lfsab_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .pop       (q_pop),
    .head      (q_head),
    .stat      (q_stat)
  );

  assign sum = {1'b0, total_r} + (TOTAL_W + 1)'(charge_r);

  // Request sequencer.
  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    mode_nxt       = mode_r;
    id_nxt         = id_r;
    w_nxt          = w_r;
    mul_rate_nxt   = mul_rate_r;
    mul_wt_nxt     = mul_wt_r;
    charge_nxt     = charge_r;
    total_nxt      = total_r;
    waiter_vld_nxt = waiter_vld_r;
    waiter_id_nxt  = waiter_id_r;
    out_event_nxt  = out_event_r;
    out_slot_nxt   = out_slot_r;
    out_who_nxt    = out_who_r;
    out_charge_nxt = out_charge_r;
    out_total_nxt  = out_total_r;
    out_last_nxt   = out_last_r;
    q_push         = 1'b0;
    q_pop          = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_beat) begin
          id_nxt  = in_requester_id;
          w_nxt   = in_weight;
          idx_nxt = '0;
          case (in_func)
            FUNC_ARRIVE: begin
              mode_nxt  = SCAN_FREE;
              state_nxt = ST_SCAN;
            end
            FUNC_DEPART: begin
              mode_nxt  = SCAN_OWNER;
              state_nxt = ST_SCAN;
            end
            FUNC_LOAD: begin
              out_event_nxt  = EV_LOADED;
              out_slot_nxt   = in_load_slot;
              out_who_nxt    = '0;
              out_charge_nxt = '0;
              out_total_nxt  = total_r;
              out_last_nxt   = 1'b1;
              state_nxt      = ST_OUT_LAST;
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end
      ST_SCAN: begin
        out_who_nxt    = id_r;
        out_charge_nxt = '0;
        out_total_nxt  = total_r;
        out_last_nxt   = 1'b1;
        if (any_hit) begin
          out_slot_nxt = SLOT_W'(idx_r);
          if (mode_r == SCAN_FREE) begin
            out_event_nxt = EV_ASSIGNED;
            state_nxt     = ST_OUT_LAST;
          end else begin
            // The cell took the queue head already; pop it here as well.
            mul_rate_nxt   = hit_rate;
            mul_wt_nxt     = hit_weight;
            waiter_vld_nxt = !q_stat.empty;
            waiter_id_nxt  = q_head.id;
            q_pop          = !q_stat.empty;
            state_nxt      = ST_MUL;
          end
        end else if (idx_r == scan_end) begin
          out_slot_nxt = '0;
          state_nxt    = ST_OUT_LAST;
          if (mode_r == SCAN_OWNER) begin
            out_event_nxt = EV_NOTFOUND;
          end else if (!q_stat.full) begin
            out_event_nxt = EV_QUEUED;
            q_push        = 1'b1;
          end else begin
            out_event_nxt = EV_FULL;
          end
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      ST_MUL: begin
        charge_nxt = CHARGE_W'(mul_rate_r) * CHARGE_W'(mul_wt_r);
        state_nxt  = ST_ADD;
      end
      ST_ADD: begin
        // Saturating running total.
        total_nxt      = sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];
        out_event_nxt  = EV_RELEASED;
        out_charge_nxt = charge_r;
        out_total_nxt  = total_nxt;
        out_last_nxt   = !waiter_vld_r;
        state_nxt      = waiter_vld_r ? ST_OUT_A : ST_OUT_LAST;
      end
      ST_OUT_A: begin
        if (out_beat) begin
          out_event_nxt  = EV_ASSIGNED;
          out_who_nxt    = waiter_id_r;
          out_charge_nxt = '0;
          out_last_nxt   = 1'b1;
          state_nxt      = ST_OUT_LAST;
        end
      end
      ST_OUT_LAST: begin
        if (out_beat) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cfg_slots_r <= CFG_W'(16);
      total_r     <= '0;
    end else begin
      state_r <= state_nxt;
      total_r <= total_nxt;
      if (cfg_wr) begin
        cfg_slots_r <= pwdata[CFG_W-1:0];
      end
    end
  end

  // Working and result registers.
  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    mode_r       <= mode_nxt;
    id_r         <= id_nxt;
    w_r          <= w_nxt;
    mul_rate_r   <= mul_rate_nxt;
    mul_wt_r     <= mul_wt_nxt;
    charge_r     <= charge_nxt;
    waiter_vld_r <= waiter_vld_nxt;
    waiter_id_r  <= waiter_id_nxt;
    out_event_r  <= out_event_nxt;
    out_slot_r   <= out_slot_nxt;
    out_who_r    <= out_who_nxt;
    out_charge_r <= out_charge_nxt;
    out_total_r  <= out_total_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_event_res = out_event_r;
  assign out_slot      = out_slot_r;
  assign out_who       = out_who_r;
  assign out_charge    = out_charge_r;
  assign out_total     = out_total_r;
  assign out_last      = out_last_r;

  // At most one cell holds the scan token, so at most one cell hits.
  a_one_hit: assert property (@(posedge clk) disable iff (!rst_n) $onehot0(hit_vec))
    else $error("more than one cell hit in a scan");

  // A request that produces results blocks intake until it finishes.
  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (in_func != FUNC_UNUSED)) |=> !in_ready)
    else $error("intake reopened while a request is in work");

  // A beat that is not the last one is followed by another result.
  a_second_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_last) |=> out_valid)
    else $error("second result beat missing");

  // Queue writes and reads respect its fill state.
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n) q_push |-> !q_stat.full)
    else $error("push into a full wait queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> !q_stat.empty)
    else $error("pop from an empty wait queue");

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import lfsab_pkg::*;

  localparam int N_SLOTS = 16;
  localparam int WAIT_DEPTH = 16;
  localparam int DRAIN_CYCLES = 40;
  localparam int LONG_HOLD = 300;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASE_ITEMS = 170;
  localparam logic [APB_AW-1:0] SLOTS_ADDR = {REG_SLOTS, 2'b00};
  localparam logic [WEIGHT_W-1:0] MAX_WEIGHT = '1;
  localparam logic [RATE_W-1:0] MAX_RATE = '1;
  localparam logic [ID_W-1:0] MAX_ID = '1;

  // One request beat as seen on the input channel.
  typedef struct packed {
    logic [FUNC_W-1:0]   func;
    logic [ID_W-1:0]     id;
    logic [WEIGHT_W-1:0] weight;
    logic [SLOT_W-1:0]   load_slot;
    logic [RATE_W-1:0]   load_rate;
  } request_t;

  // One result beat as seen on the output channel.
  typedef struct packed {
    logic [EV_W-1:0]     event_res;
    logic [SLOT_W-1:0]   slot;
    logic [ID_W-1:0]     who;
    logic [CHARGE_W-1:0] charge;
    logic [TOTAL_W-1:0]  total;
    logic                last;
  } outcome_t;

  // Mirror of the allocator: slot table, wait line and charge total, plus the
  // result beats that the accepted requests still owe.
  class slot_ledger;
    bit [CFG_W-1:0]    slot_count;
    bit [RATE_W-1:0]   rate [N_SLOTS];
    bit                busy [N_SLOTS];
    bit [ID_W-1:0]     owner [N_SLOTS];
    bit [WEIGHT_W-1:0] held_weight [N_SLOTS];
    request_t          waiting [$];
    bit [TOTAL_W-1:0]  charge_total;
    outcome_t          due_events [$];
    int                failures;

    function new();
      slot_count = 5'd16;
      charge_total = '0;
      failures = 0;
      foreach (busy[i]) busy[i] = 1'b0;
    endfunction

    function void add_outcome(logic [EV_W-1:0] ev, int slot, logic [ID_W-1:0] who,
                              logic [CHARGE_W-1:0] charge);
      outcome_t o;
      o.event_res = ev;
      o.slot = SLOT_W'(slot);
      o.who = who;
      o.charge = charge;
      o.total = charge_total;
      o.last = 1'b0;
      due_events.push_back(o);
    endfunction

    // Work out the result beats of one accepted request and update the state.
    function void note_request(request_t r);
      int lim;
      int hit;
      int start_depth;
      request_t head;
      bit [CHARGE_W-1:0] charge;
      bit [TOTAL_W:0] sum;
      lim = (slot_count > N_SLOTS) ? N_SLOTS : int'(slot_count);
      hit = -1;
      start_depth = due_events.size();
      case (r.func)
        FUNC_ARRIVE: begin
          for (int i = 0; i < lim; i++)
            if (!busy[i] && hit < 0) hit = i;
          if (hit >= 0) begin
            busy[hit] = 1'b1;
            owner[hit] = r.id;
            held_weight[hit] = r.weight;
            add_outcome(EV_ASSIGNED, hit, r.id, '0);
          end else if (waiting.size() < WAIT_DEPTH) begin
            waiting.push_back(r);
            add_outcome(EV_QUEUED, 0, r.id, '0);
          end else begin
            add_outcome(EV_FULL, 0, r.id, '0);
          end
        end
        FUNC_DEPART: begin
          // The owner search covers every slot, also those past the slot count.
          for (int i = 0; i < N_SLOTS; i++)
            if (busy[i] && owner[i] == r.id && hit < 0) hit = i;
          if (hit >= 0) begin
            charge = rate[hit] * held_weight[hit];
            sum = charge_total + charge;
            charge_total = sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];
            busy[hit] = 1'b0;
            add_outcome(EV_RELEASED, hit, r.id, charge);
            if (waiting.size() > 0) begin
              head = waiting.pop_front();
              busy[hit] = 1'b1;
              owner[hit] = head.id;
              held_weight[hit] = head.weight;
              add_outcome(EV_ASSIGNED, hit, head.id, '0);
            end
          end else begin
            add_outcome(EV_NOTFOUND, 0, r.id, '0);
          end
        end
        FUNC_LOAD: begin
          rate[r.load_slot] = r.load_rate;
          add_outcome(EV_LOADED, int'(r.load_slot), '0, '0);
        end
        default: ;
      endcase
      if (due_events.size() > start_depth) due_events[due_events.size()-1].last = 1'b1;
    endfunction

    function void compare_field(string name, logic [TOTAL_W-1:0] want,
                                logic [TOTAL_W-1:0] got);
      if (want !== got) begin
        $error("%s mismatch: expected %0d, got %0d", name, want, got);
        failures++;
      end
    endfunction

    // Compare one accepted result beat with the oldest one still owed.
    function void check_result(outcome_t got);
      outcome_t want;
      if (due_events.size() == 0) begin
        $error("result beat with nothing owed: event_res %0d who %0d", got.event_res,
               got.who);
        failures++;
        return;
      end
      want = due_events.pop_front();
      compare_field("event_res", want.event_res, got.event_res);
      compare_field("slot", want.slot, got.slot);
      compare_field("who", want.who, got.who);
      compare_field("charge", want.charge, got.charge);
      compare_field("total", want.total, got.total);
      compare_field("last", want.last, got.last);
    endfunction

    function int pending();
      return due_events.size();
    endfunction

    // Index of a busy slot, the lowest or a random one; -1 when none is busy.
    function int busy_slot_pick(bit lowest);
      int hits [$];
      foreach (busy[i]) if (busy[i]) hits.push_back(i);
      if (hits.size() == 0) return -1;
      return lowest ? hits[0] : hits[$urandom_range(0, hits.size() - 1)];
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic [FUNC_W-1:0] in_func;
  logic [ID_W-1:0] in_requester_id;
  logic [WEIGHT_W-1:0] in_weight;
  logic [SLOT_W-1:0] in_load_slot;
  logic [RATE_W-1:0] in_load_rate;
  logic out_valid;
  logic out_ready;
  logic [EV_W-1:0] out_event_res;
  logic [SLOT_W-1:0] out_slot;
  logic [ID_W-1:0] out_who;
  logic [CHARGE_W-1:0] out_charge;
  logic [TOTAL_W-1:0] out_total;
  logic out_last;
  logic psel;
  logic penable;
  logic pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic pready;

  slot_ledger ledger = new();
  bit steady = 1'b0;
  bit hold_off_request = 1'b0;
  int quiet_cycles = 0;

  lowest_free_slot_allocator_billing_unit i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_func         (in_func),
    .in_requester_id (in_requester_id),
    .in_weight       (in_weight),
    .in_load_slot    (in_load_slot),
    .in_load_rate    (in_load_rate),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_event_res   (out_event_res),
    .out_slot        (out_slot),
    .out_who         (out_who),
    .out_charge      (out_charge),
    .out_total       (out_total),
    .out_last        (out_last),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  // Clock, 10 ns period.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Abort when no beat of any kind moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (psel && penable && pready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic int idle_draw();
    return steady ? 0 : int'($urandom_range(0, 15));
  endfunction

  function automatic request_t make_req(logic [FUNC_W-1:0] func, logic [ID_W-1:0] id,
                                        logic [WEIGHT_W-1:0] weight,
                                        logic [SLOT_W-1:0] load_slot,
                                        logic [RATE_W-1:0] load_rate);
    request_t r;
    r.func = func;
    r.id = id;
    r.weight = weight;
    r.load_slot = load_slot;
    r.load_rate = load_rate;
    return r;
  endfunction

  // Offer one request beat after a random gap and hold it until taken.
  task automatic offer(input request_t r);
    int gap;
    gap = idle_draw();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_func <= r.func;
    in_requester_id <= r.id;
    in_weight <= r.weight;
    in_load_slot <= r.load_slot;
    in_load_rate <= r.load_rate;
    do @(posedge clk); while (!(in_valid && in_ready));
    ledger.note_request(r);
  endtask

  // Stop offering, wait for every owed beat, then let a silent request finish.
  task automatic drain();
    in_valid <= 1'b0;
    while (ledger.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write the slot count register while the block is idle.
  task automatic change_slot_count(input logic [CFG_W-1:0] value);
    drain();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= SLOTS_ADDR;
    pwdata <= APB_DW'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    ledger.slot_count = value;
  endtask

  // Mostly arrivals and departures of held requesters, with some loads and noise.
  task automatic offer_random(output bit counted);
    request_t r;
    int pick;
    int s;
    r.func = FUNC_ARRIVE;
    r.id = ID_W'($urandom_range(0, 1023));
    r.load_slot = SLOT_W'($urandom_range(0, 15));
    r.load_rate = RATE_W'($urandom_range(0, 255));
    case ($urandom_range(0, 3))
      0: r.weight = MAX_WEIGHT;
      1: r.weight = WEIGHT_W'($urandom_range(0, 255));
      default: r.weight = WEIGHT_W'($urandom_range(0, 16383));
    endcase
    pick = $urandom_range(0, 99);
    counted = 1'b1;
    if (pick < 45) begin
      r.func = FUNC_ARRIVE;
    end else if (pick < 85) begin
      r.func = FUNC_DEPART;
      s = ledger.busy_slot_pick(1'b0);
      if (s >= 0 && $urandom_range(0, 9) < 8) r.id = ledger.owner[s];
    end else if (pick < 97) begin
      r.func = FUNC_LOAD;
      if ($urandom_range(0, 1) == 1) r.load_rate = RATE_W'($urandom_range(200, 255));
    end else begin
      r.func = FUNC_UNUSED;
      counted = 1'b0;
    end
    offer(r);
  endtask

  // Result side: random stalls, one long hold-off on request.
  initial begin
    int stall;
    outcome_t got;
    out_ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      stall = idle_draw();
      if (hold_off_request) begin
        stall = LONG_HOLD;
        hold_off_request = 1'b0;
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
      got.event_res = out_event_res;
      got.slot = out_slot;
      got.who = out_who;
      got.charge = out_charge;
      got.total = out_total;
      got.last = out_last;
      ledger.check_result(got);
    end
  end

  // Stimulus.
  initial begin
    logic [CFG_W-1:0] phase_counts [10];
    int counted_items;
    int s;
    bit counted;

    phase_counts = '{5'd16, 5'd3, 5'd1, 5'd0, 5'd31, 5'd7, 5'd2, 5'd17, 5'd16, 5'd5};
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_func <= FUNC_ARRIVE;
    in_requester_id <= '0;
    in_weight <= '0;
    in_load_slot <= '0;
    in_load_rate <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Load every rate word first, so no release ever reads an unwritten one.
    for (int i = 0; i < N_SLOTS; i++)
      offer(make_req(FUNC_LOAD, ID_W'($urandom_range(0, 1023)),
                     WEIGHT_W'($urandom_range(0, 16383)),
                     SLOT_W'(i),
                     (i == 0) ? MAX_RATE : (i == N_SLOTS - 1) ? '0 :
                     RATE_W'($urandom_range(0, 255))));

    // Extreme fields, an unknown departure and an unused function code.
    offer(make_req(FUNC_ARRIVE, MAX_ID, MAX_WEIGHT, '0, '0));
    offer(make_req(FUNC_ARRIVE, '0, '0, '1, '1));
    offer(make_req(FUNC_UNUSED, MAX_ID, MAX_WEIGHT, '1, '1));
    offer(make_req(FUNC_DEPART, MAX_ID, '0, '0, '0));
    offer(make_req(FUNC_DEPART, 10'd777, '0, '0, '0));
    offer(make_req(FUNC_DEPART, '0, '0, '0, '0));

    // No usable slots, then a release that hands its slot to a waiter.
    change_slot_count(5'd0);
    offer(make_req(FUNC_ARRIVE, 10'd5, 14'd100, '0, '0));
    change_slot_count(5'd1);
    offer(make_req(FUNC_ARRIVE, 10'd6, MAX_WEIGHT, '0, '0));
    offer(make_req(FUNC_DEPART, 10'd6, '0, '0, '0));
    offer(make_req(FUNC_DEPART, 10'd5, '0, '0, '0));

    // Random phases, one per slot count setting.
    foreach (phase_counts[p]) begin
      change_slot_count(phase_counts[p]);
      counted_items = 0;
      while (counted_items < PHASE_ITEMS) begin
        if (counted_items % 64 == 0) steady = ($urandom_range(0, 3) == 0);
        if (p == 2 && counted_items == 50) hold_off_request = 1'b1;
        offer_random(counted);
        if (counted) counted_items++;
      end
    end

    // Empty the slots and the wait line.
    steady = 1'b1;
    s = ledger.busy_slot_pick(1'b1);
    while (s >= 0 || ledger.waiting.size() > 0) begin
      if (s >= 0) offer(make_req(FUNC_DEPART, ledger.owner[s], '0, '0, '0));
      else offer(make_req(FUNC_ARRIVE, ID_W'($urandom_range(0, 1023)), MAX_WEIGHT, '0, '0));
      s = ledger.busy_slot_pick(1'b1);
    end

    drain();
    if (ledger.failures == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule

FILE: sim.f
hdl/lfsab_pkg.sv
hdl/lfsab_cell.sv
hdl/lfsab_queue.sv
hdl/lowest_free_slot_allocator_billing_unit.sv
tb/testbench.sv
